[hw/rtl/rwmf_pkg.sv]
// Shared constants, types and helper functions of the RGB window median filter.
// No dependencies; every other file of the block but rwmf_ram imports this package.
`default_nettype none

package rwmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 3;

  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int PIX_W     = NUM_CHAN * CHAN_W;
  localparam int WIN_SIDE  = 2 * MAX_RADIUS + 1;
  localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
  localparam int LINE_ROWS = 2 * MAX_RADIUS;
  localparam int LINE_W    = LINE_ROWS * PIX_W;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W     = $clog2(WIN_CELLS + 1);
  localparam int MED_LAT   = CHAN_W + 1;

  // configuration register widths
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 16;
  localparam int RAD_CFG_W    = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam int POS_W        = 28;
  localparam int FIFO_DEPTH   = 16;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MIN_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MIN_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MAX_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MAX_Y    = 3'd6;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0] pixel_t;   // [0] red, [1] green, [2] blue
  typedef logic [RAD_W-1:0] rad_t;
  typedef pixel_t [WIN_SIDE-1:0] column_t; // [k] = k rows back

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  addr;
    pixel_t            pix;
  } line_req_t;

  typedef struct packed {
    logic res;
    logic filt;
    logic last;
    rad_t rad;
  } ctrl_t;

  typedef struct packed {
    logic   res;
    logic   filt;
    logic   last;
    pixel_t centre;
  } side_t;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } out_t;

  // cells of the 2r+1 square inside the full window
  function automatic logic [WIN_CELLS-1:0] win_mask(input rad_t r);
    logic [WIN_CELLS-1:0] m;
    m = '0;
    for (int a = 0; a < WIN_SIDE; a++) begin
      for (int k = 0; k < WIN_SIDE; k++) begin
        m[a*WIN_SIDE+k] = (a <= 2 * int'(r)) && (k <= 2 * int'(r));
      end
    end
    return m;
  endfunction

  // zero-based rank of the median: N>>1 with N = (2r+1)^2
  function automatic logic [CNT_W-1:0] win_rank(input rad_t r);
    int n;
    n = (2 * int'(r) + 1) * (2 * int'(r) + 1);
    return CNT_W'(n >> 1);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rwmf_if.sv]
// Valid/ready stream interfaces for pixel items and result items.
// Depends on rwmf_pkg for field widths.
`default_nettype none

interface rwmf_pixel_if;
  import rwmf_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface rwmf_result_if;
  import rwmf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/rgb_window_median_filter_core.sv]
// Top level of the RGB window median filter: configuration, frame counters,
// result queue. Depends on rwmf_pkg, rwmf_if, rwmf_window and rwmf_median.
`default_nettype none

// Takes one raster pixel item per clock while ready is high and returns each
// pixel r*W+r items later; flush items drain the end of a frame. Inside the
// configured zone, less an r+1 margin, each channel is replaced by the
// median of its (2r+1)^2 window, elsewhere the pixel passes. Sustained rate
// is one item per cycle while the queue has room, set by the single
// read-modify-write of the line RAM (6 rows x MAX_WIDTH) per item. A result
// passes two line/window stages and nine median stages into a 16-entry result
// queue; the input takes items as long as fewer than 16 results are in flight
// or queued. Items that give no result (frame fill, idle flush) take no queue
// slot, so while the output is stalled the input blocks after 16 result items. No clearing pass.
module rgb_window_median_filter_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [rwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rwmf_pkg::CFG_DATA_W-1:0] cfg_data,
  rwmf_pixel_if.sink                           pixel_stream,
  rwmf_result_if.source                        result_stream
);
  import rwmf_pkg::*;

  localparam int CMP_W   = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int XW      = WIDTH_W + 2;
  localparam int YW      = HEIGHT_W + 2;
  localparam int DELAY_W = WIDTH_W + RAD_W + 1;

  logic [WIDTH_W-1:0]   cfg_width, cfg_min_x, cfg_max_x;
  logic [HEIGHT_W-1:0]  cfg_height, cfg_min_y, cfg_max_y;
  logic [RAD_CFG_W-1:0] cfg_radius;

  logic [WIDTH_W-1:0]   w_eff, w_m1, ex;
  logic [HEIGHT_W-1:0]  h_eff, h_m1, ey;
  rad_t                 r_eff;
  logic [DELAY_W-1:0]   delay;

  logic [COL_W-1:0]     in_column, out_column;
  logic [HEIGHT_W-1:0]  out_row;
  logic [POS_W-1:0]     pos, pos_next;
  logic [CMP_W-1:0]     in_col_inc, out_col_inc;

  logic signed [XW-1:0] x_lo, x_hi, ox;
  logic signed [YW-1:0] y_lo, y_hi, oy;

  logic      acc, idle_flush, has_res, in_zone, last;
  pixel_t    in_pix;
  line_req_t req;
  ctrl_t     c1, c2;
  side_t     side [MED_LAT];
  pixel_t    win [WIN_CELLS];
  pixel_t    centre;
  chan_t     med [NUM_CHAN];

  logic [FIFO_CNT_W-1:0] occ, fifo_cnt;
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  out_t                  fifo_mem [FIFO_DEPTH];
  out_t                  head;
  logic                  push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_W'(1024);
      cfg_height <= HEIGHT_W'(1);
      cfg_radius <= RAD_CFG_W'(1);
      cfg_min_x  <= '0;
      cfg_min_y  <= '0;
      cfg_max_x  <= WIDTH_W'(1024);
      cfg_max_y  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_height <= cfg_data[HEIGHT_W-1:0];
        REG_WINDOW_RADIUS: cfg_radius <= cfg_data[RAD_CFG_W-1:0];
        REG_ZONE_MIN_X:    cfg_min_x  <= cfg_data[WIDTH_W-1:0];
        REG_ZONE_MIN_Y:    cfg_min_y  <= cfg_data[HEIGHT_W-1:0];
        REG_ZONE_MAX_X:    cfg_max_x  <= cfg_data[WIDTH_W-1:0];
        REG_ZONE_MAX_Y:    cfg_max_y  <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry and zone bounds
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_width;
    end
    h_eff = (cfg_height == '0) ? HEIGHT_W'(1) : cfg_height;
    r_eff = (int'(cfg_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(cfg_radius);
    w_m1  = w_eff - WIDTH_W'(1);
    h_m1  = h_eff - HEIGHT_W'(1);
    delay = DELAY_W'(r_eff) * DELAY_W'(w_eff) + DELAY_W'(r_eff);
    ex    = (cfg_max_x < w_eff) ? cfg_max_x : w_eff;
    ey    = (cfg_max_y < h_eff) ? cfg_max_y : h_eff;
    x_lo  = signed'(XW'(cfg_min_x) + XW'(r_eff) + XW'(1));
    x_hi  = signed'(XW'(ex) - XW'(r_eff) - XW'(2));
    y_lo  = signed'(YW'(cfg_min_y) + YW'(r_eff) + YW'(1));
    y_hi  = signed'(YW'(ey) - YW'(r_eff) - YW'(2));
    ox    = signed'(XW'(out_column));
    oy    = signed'(YW'(out_row));
  end

  // accept-cycle decisions
  always_comb begin
    acc        = pixel_stream.valid && pixel_stream.ready;
    idle_flush = pixel_stream.op && (pos == '0);
    in_pix     = pixel_stream.op ? '0 :
                 {pixel_stream.blue_in, pixel_stream.green_in, pixel_stream.red_in};
    pos_next   = (pos == '1) ? pos : pos + POS_W'(1);
    has_res    = !idle_flush && (pos_next > POS_W'(delay));
    in_zone    = (cfg_max_y != '0) && (ox >= x_lo) && (ox <= x_hi) &&
                 (oy >= y_lo) && (oy <= y_hi);
    last       = (out_row >= h_m1) && (CMP_W'(out_column) >= CMP_W'(w_m1));
    in_col_inc  = CMP_W'(in_column) + CMP_W'(1);
    out_col_inc = CMP_W'(out_column) + CMP_W'(1);
    req.valid  = acc && !idle_flush;
    req.addr   = in_column;
    req.pix    = in_pix;
  end

  // frame position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      in_column  <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (acc && !idle_flush) begin
      if (has_res && last) begin
        pos        <= '0;
        in_column  <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        pos <= pos_next;
        if (in_col_inc >= CMP_W'(w_eff)) begin
          in_column <= '0;
        end else begin
          in_column <= in_col_inc[COL_W-1:0];
        end
        if (has_res) begin
          if (out_col_inc >= CMP_W'(w_eff)) begin
            out_column <= '0;
            out_row    <= out_row + HEIGHT_W'(1);
          end else begin
            out_column <= out_col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  rwmf_window u_window (
    .clk (clk),
    .rst (rst),
    .req (req),
    .win (win)
  );

  // centre cell for the item's radius
  always_comb begin
    centre = win[0];
    for (int rr = 0; rr <= MAX_RADIUS; rr++) begin
      if (c2.rad == RAD_W'(rr)) begin
        centre = win[rr*WIN_SIDE+rr];
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    chan_t ch_vals [WIN_CELLS];
    always_comb begin
      for (int i = 0; i < WIN_CELLS; i++) begin
        ch_vals[i] = win[i][ch];
      end
    end
    rwmf_median u_median (
      .clk  (clk),
      .vals (ch_vals),
      .mask (win_mask(c2.rad)),
      .rank (win_rank(c2.rad)),
      .med  (med[ch])
    );
  end

  // sideband aligned with the line stage, window stage and median pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      for (int s = 0; s < MED_LAT; s++) begin
        side[s] <= '0;
      end
    end else begin
      c1.res  <= acc && has_res;
      c1.filt <= in_zone;
      c1.last <= last;
      c1.rad  <= r_eff;
      c2      <= c1;
      side[0].res    <= c2.res;
      side[0].filt   <= c2.filt;
      side[0].last   <= c2.last;
      side[0].centre <= centre;
      for (int s = 1; s < MED_LAT; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  // result queue with credit count over in-flight and queued results
  assign push = side[MED_LAT-1].res;
  assign pop  = result_stream.valid && result_stream.ready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      fifo_cnt <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
    end else begin
      occ      <= occ + FIFO_CNT_W'(acc && has_res) - FIFO_CNT_W'(pop);
      fifo_cnt <= fifo_cnt + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
    end
    if (push) begin
      fifo_mem[wr_ptr].last <= side[MED_LAT-1].last;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        fifo_mem[wr_ptr].pix[ch] <= side[MED_LAT-1].filt ? med[ch] :
                                    side[MED_LAT-1].centre[ch];
      end
    end
  end

  assign pixel_stream.ready      = (occ < FIFO_CNT_W'(FIFO_DEPTH));
  assign result_stream.valid     = (fifo_cnt != '0);
  assign result_stream.red_out   = head.pix[0];
  assign result_stream.green_out = head.pix[1];
  assign result_stream.blue_out  = head.pix[2];
  assign result_stream.frame_end = head.last;

endmodule

`default_nettype wire

[hw/rtl/rwmf_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module rwmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/rwmf_window.sv]
// Line store and window shift registers: one read-modify-write per item.
// Depends on rwmf_pkg and rwmf_ram.
`default_nettype none

module rwmf_window (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rwmf_pkg::line_req_t req,
  output rwmf_pkg::pixel_t         win [rwmf_pkg::WIN_CELLS]
);
  import rwmf_pkg::*;

  logic [LINE_W-1:0] rdata;
  logic [LINE_W-1:0] rd_eff;
  logic [LINE_W-1:0] wdata;
  logic              s1_valid;
  logic [COL_W-1:0]  s1_addr;
  pixel_t            s1_pix;
  logic              lw_valid;
  logic [COL_W-1:0]  lw_addr;
  logic [LINE_W-1:0] lw_data;
  column_t           col_new;
  column_t           cols [WIN_SIDE];

  rwmf_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (wdata),
    .raddr (req.addr),
    .rdata (rdata)
  );

  // the write of the previous cycle is not yet in the read data
  always_comb begin
    rd_eff = (lw_valid && lw_addr == s1_addr) ? lw_data : rdata;
    col_new[0] = s1_pix;
    for (int k = 1; k < WIN_SIDE; k++) begin
      col_new[k] = rd_eff[(k-1)*PIX_W +: PIX_W];
    end
    for (int k = 0; k < LINE_ROWS; k++) begin
      wdata[k*PIX_W +: PIX_W] = col_new[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
      lw_valid <= s1_valid;
    end
    s1_addr <= req.addr;
    s1_pix  <= req.pix;
    lw_addr <= s1_addr;
    lw_data <= wdata;
    if (s1_valid) begin
      cols[0] <= col_new;
      for (int a = 1; a < WIN_SIDE; a++) begin
        cols[a] <= cols[a-1];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < WIN_SIDE; a++) begin
      for (int k = 0; k < WIN_SIDE; k++) begin
        win[a*WIN_SIDE+k] = cols[a][k];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rwmf_median.sv]
// Pipelined radix-select median of one colour channel over the window.
// One bit decided per stage, MSB first. Depends on rwmf_pkg.
`default_nettype none

module rwmf_median (
  input  wire logic                          clk,
  input  wire rwmf_pkg::chan_t               vals [rwmf_pkg::WIN_CELLS],
  input  wire logic [rwmf_pkg::WIN_CELLS-1:0] mask,
  input  wire logic [rwmf_pkg::CNT_W-1:0]    rank,
  output rwmf_pkg::chan_t                    med
);
  import rwmf_pkg::*;

  chan_t                sv [CHAN_W+1][WIN_CELLS];
  logic [WIN_CELLS-1:0] sm [CHAN_W+1];
  logic [CNT_W-1:0]     sr [CHAN_W+1];
  chan_t                so [CHAN_W+1];

  always_ff @(posedge clk) begin
    sv[0] <= vals;
    sm[0] <= mask;
    sr[0] <= rank;
    so[0] <= '0;
  end

  for (genvar s = 0; s < CHAN_W; s++) begin : g_stage
    localparam int BIT = CHAN_W - 1 - s;
    logic [CNT_W-1:0]     zeros;
    logic [WIN_CELLS-1:0] bitv;
    logic                 one_bit;

    always_comb begin
      zeros = '0;
      for (int i = 0; i < WIN_CELLS; i++) begin
        bitv[i] = sv[s][i][BIT];
        zeros   = zeros + CNT_W'(sm[s][i] & ~sv[s][i][BIT]);
      end
      one_bit = (sr[s] >= zeros);
    end

    // keep only the candidates that agree with the decided bit
    always_ff @(posedge clk) begin
      sv[s+1] <= sv[s];
      sm[s+1] <= sm[s] & (one_bit ? bitv : ~bitv);
      sr[s+1] <= one_bit ? sr[s] - zeros : sr[s];
      so[s+1] <= so[s] | (CHAN_W'(one_bit) << BIT);
    end
  end

  assign med = so[CHAN_W];

endmodule

`default_nettype wire

[hw/rtl/rwmf_checker.sv]
// Port-level checks of the median filter top level and their bind.
// Depends on rwmf_pkg and rgb_window_median_filter_core.
`default_nettype none

module rwmf_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [rwmf_pkg::PIX_W:0] out_payload
);
  import rwmf_pkg::*;

  logic [31:0] in_count;
  logic [31:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_count <= in_count + 32'd1;
      end
      if (out_valid && out_ready) begin
        out_count <= out_count + 32'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result item changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset left a result pending or input blocked");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_count <= in_count)
    else $error("more result items than accepted items");

endmodule

bind rgb_window_median_filter_core rwmf_checker u_rwmf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixel_stream.valid),
  .in_ready    (pixel_stream.ready),
  .out_valid   (result_stream.valid),
  .out_ready   (result_stream.ready),
  .out_payload ({result_stream.frame_end, result_stream.blue_out,
                 result_stream.green_out, result_stream.red_out})
);

`default_nettype wire

[bench/tb_rgb_window_median_filter_core.sv]
// Testbench of rgb_window_median_filter_core: frames of random and extreme pixels,
// checked item by item against a median predictor. Depends on rwmf_pkg and rwmf_if.
`timescale 1ns / 1ps

class median_scoreboard;
  localparam int HIST = 2 * rwmf_pkg::MAX_RADIUS * rwmf_pkg::MAX_WIDTH
                        + 2 * rwmf_pkg::MAX_RADIUS + 1;

  rwmf_pkg::pixel_t history[HIST];
  int               wr_idx;
  int unsigned      in_col, in_row, out_col, out_row;
  int unsigned      width_reg, height_reg, radius_reg;
  int unsigned      zmin_x, zmin_y, zmax_x, zmax_y;
  rwmf_pkg::out_t   pending_results[$];
  int               errors;
  bit               frame_done;

  function new();
    width_reg = 1024; height_reg = 1; radius_reg = 1;
    zmin_x = 0; zmin_y = 0; zmax_x = 1024; zmax_y = 0;
    foreach (history[i]) history[i] = '0;
    wr_idx = 0; in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    errors = 0; frame_done = 0;
  endfunction

  function void report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction

  function void set_reg(logic [rwmf_pkg::CFG_IDX_W-1:0] idx,
                        logic [rwmf_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      rwmf_pkg::REG_IMAGE_WIDTH:   width_reg  = val[10:0];
      rwmf_pkg::REG_IMAGE_HEIGHT:  height_reg = val;
      rwmf_pkg::REG_WINDOW_RADIUS: radius_reg = val[1:0];
      rwmf_pkg::REG_ZONE_MIN_X:    zmin_x     = val[10:0];
      rwmf_pkg::REG_ZONE_MIN_Y:    zmin_y     = val;
      rwmf_pkg::REG_ZONE_MAX_X:    zmax_x     = val[10:0];
      rwmf_pkg::REG_ZONE_MAX_Y:    zmax_y     = val;
      default: ;
    endcase
  endfunction

  function rwmf_pkg::pixel_t look_back(longint b);
    return history[(wr_idx + HIST - (b % HIST)) % HIST];
  endfunction

  // advance the frame position and queue the pixel that leaves, if any
  function void note_item(bit is_flush, rwmf_pkg::pixel_t p);
    longint w, h, r, d, pos, ex, ey, ox, oy;
    rwmf_pkg::pixel_t px, res, nb;
    rwmf_pkg::chan_t vals[$];
    rwmf_pkg::out_t o;
    bit last;
    w = width_reg; h = height_reg; r = radius_reg;
    if (w == 0) w = 1;
    if (w > rwmf_pkg::MAX_WIDTH) w = rwmf_pkg::MAX_WIDTH;
    if (h == 0) h = 1;
    if (r > rwmf_pkg::MAX_RADIUS) r = rwmf_pkg::MAX_RADIUS;
    frame_done = 0;
    // drop a flush while no frame is open
    if (is_flush && in_col == 0 && in_row == 0) return;
    px = is_flush ? '0 : p;
    wr_idx = (wr_idx + 1) % HIST;
    history[wr_idx] = px;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    d = r * w + r;
    pos = longint'(in_row) * w + in_col;
    if (pos <= d) return;
    res = look_back(d);
    ex = (zmax_x < w) ? zmax_x : w;
    ey = (zmax_y < h) ? zmax_y : h;
    ox = longint'(out_col);
    oy = longint'(out_row);
    if (zmax_y != 0 && ox >= longint'(zmin_x) + r + 1 && ox <= ex - r - 2 &&
        oy >= longint'(zmin_y) + r + 1 && oy <= ey - r - 2) begin
      for (int ch = 0; ch < rwmf_pkg::NUM_CHAN; ch++) begin
        vals.delete();
        for (longint j = -r; j <= r; j++)
          for (longint i = -r; i <= r; i++) begin
            nb = look_back(d - (j * w + i));
            vals.push_back(nb[ch]);
          end
        vals.sort();
        res[ch] = vals[vals.size() / 2];
      end
    end
    last = (out_row >= h - 1) && (out_col >= w - 1);
    o.pix = res;
    o.last = last;
    pending_results.push_back(o);
    if (last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_done = 1;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function void check_result(rwmf_pkg::out_t got);
    rwmf_pkg::out_t exp_o;
    if (pending_results.size() == 0) begin
      report("result with no pixel pending");
      return;
    end
    exp_o = pending_results.pop_front();
    if (got.pix[0] !== exp_o.pix[0])
      report($sformatf("red_out got %0d exp %0d", got.pix[0], exp_o.pix[0]));
    if (got.pix[1] !== exp_o.pix[1])
      report($sformatf("green_out got %0d exp %0d", got.pix[1], exp_o.pix[1]));
    if (got.pix[2] !== exp_o.pix[2])
      report($sformatf("blue_out got %0d exp %0d", got.pix[2], exp_o.pix[2]));
    if (got.last !== exp_o.last)
      report($sformatf("frame_end got %0b exp %0b", got.last, exp_o.last));
  endfunction
endclass

module tb_rgb_window_median_filter_core;
  import rwmf_pkg::*;

  localparam bit OP_PIXEL = 1'b0;
  localparam bit OP_FLUSH = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 30;
  localparam int ITEM_TARGET = 1050;
  localparam int MIN_RANDOM_FRAMES = 3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  rwmf_pixel_if          pix_if ();
  rwmf_result_if         res_if ();

  median_scoreboard sb;
  int  cycles;
  int  sent_items;
  bit  long_hold;

  rgb_window_median_filter_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_stream  (pix_if.sink),
    .result_stream (res_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.pix[0] = res_if.red_out;
      got.pix[1] = res_if.green_out;
      got.pix[2] = res_if.blue_out;
      got.last   = res_if.frame_end;
      sb.check_result(got);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic pixel_t pick_pixel(bit extremes);
    pixel_t p;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      if (extremes || $urandom_range(0, 9) == 0)
        p[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else
        p[ch] = $urandom_range(0, 255);
    end
    return p;
  endfunction

  // receiver: random ready with stretches, and one long hold on request
  initial begin
    int g;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      g = pick_gap(30);
      if (g > 0) begin
        res_if.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic send_item(bit op, pixel_t p);
    pix_if.valid    <= 1'b1;
    pix_if.op       <= op;
    pix_if.red_in   <= p[0];
    pix_if.green_in <= p[1];
    pix_if.blue_in  <= p[2];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    sb.note_item(op, p);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r, int unsigned x0,
                           int unsigned y0, int unsigned x1, int unsigned y1);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RADIUS, r);
    write_reg(REG_ZONE_MIN_X, x0);
    write_reg(REG_ZONE_MIN_Y, y0);
    write_reg(REG_ZONE_MAX_X, x1);
    write_reg(REG_ZONE_MAX_Y, y1);
  endtask

  // hold the input until every pending result is out, then let the pipe settle
  task automatic drain();
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one full frame: pixels, rare in-frame flushes, then flushes until frame_end
  task automatic run_frame(int unsigned w_eff, int unsigned h_eff, bit extremes);
    int n;
    int g;
    n = 0;
    if ($urandom_range(0, 3) == 0 || extremes) send_item(OP_FLUSH, pick_pixel(0));
    do begin
      if (n < w_eff * h_eff && !(extremes && n == 2) && $urandom_range(0, 24) != 0)
        send_item(OP_PIXEL, pick_pixel(extremes));
      else
        send_item(OP_FLUSH, pick_pixel(0));
      n++;
      g = pick_gap(65);
      if (g > 0 && !sb.frame_done) begin
        pix_if.valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end while (!sb.frame_done);
    pix_if.valid <= 1'b0;
    drain();
  endtask

  function automatic int unsigned pick_zone(int unsigned lim, int unsigned top);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  initial begin
    int unsigned w, h, r;
    int rand_frames;
    sb = new();
    cycles = 0;
    sent_items = 0;
    rand_frames = 0;
    long_hold = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.op = OP_PIXEL;
    pix_if.red_in = '0;
    pix_if.green_in = '0;
    pix_if.blue_in = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: small frame with extreme colors, idle and in-frame flushes
    set_frame(4, 3, 0, 0, 0, 1024, 65535);
    run_frame(4, 3, 1);
    // zero width and height act as one
    set_frame(0, 0, 3, 0, 0, 0, 1);
    run_frame(1, 1, 1);
    // oversized width clamps to the maximum; output held off meanwhile
    write_reg(REG_IMAGE_HEIGHT, 65535);
    set_frame(2047, 1, 0, 1024, 65535, 2047, 65535);
    long_hold = 1;
    run_frame(MAX_WIDTH, 1, 0);
    // filtered interior with the largest radius
    set_frame(10, 10, 3, 0, 0, 1024, 65535);
    run_frame(10, 10, 0);

    while (sent_items < ITEM_TARGET || rand_frames < MIN_RANDOM_FRAMES) begin
      w = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
      h = $urandom_range(1, 10);
      r = $urandom_range(0, 3);
      set_frame(w, h, r, pick_zone(3, 1024), pick_zone(3, 65535),
                pick_zone(12, 1024), pick_zone(12, 65535));
      run_frame(w, h, 0);
      rand_frames++;
    end

    drain();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/rwmf_pkg.sv
hw/rtl/rwmf_if.sv
hw/rtl/rwmf_ram.sv
hw/rtl/rwmf_window.sv
hw/rtl/rwmf_median.sv
hw/rtl/rgb_window_median_filter_core.sv
hw/rtl/rwmf_checker.sv
bench/tb_rgb_window_median_filter_core.sv
